@@ rtl/assert_macros.svh @@
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while in reset
`define TLSF_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define TLSF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/tlsf_pkg.sv @@
// shared types, constants and the trigraph table of the trigraph and splice filter
`default_nettype none

package tlsf_pkg;

	localparam int LINE_BITS  = 24;
	localparam int CHAR_BITS  = 8;
	localparam int OUT_DATA_W = CHAR_BITS + LINE_BITS;
	localparam int Q_DEPTH    = 4;
	localparam int Q_AW       = $clog2(Q_DEPTH);

	localparam logic [LINE_BITS-1:0] LINE_ONE = LINE_BITS'(1);
	localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};

	localparam logic [CHAR_BITS-1:0] CH_NUL   = 8'h00;
	localparam logic [CHAR_BITS-1:0] CH_LF    = 8'h0A;
	localparam logic [CHAR_BITS-1:0] CH_CR    = 8'h0D;
	localparam logic [CHAR_BITS-1:0] CH_QMARK = 8'h3F;
	localparam logic [CHAR_BITS-1:0] CH_BSL   = 8'h5C;
	localparam logic [CHAR_BITS-1:0] CH_SLASH = 8'h2F;

	// one queued work record: up to three results, or a bare splice
	typedef struct packed {
		logic [1:0]                  cnt;
		logic [2:0][CHAR_BITS-1:0]   ch;
		logic                        splice;
		logic                        is_end;
	} tlsf_rec_t;

	typedef struct packed {
		logic                  hit;
		logic [CHAR_BITS-1:0]  ch;
	} tri_map_t;

	function automatic tri_map_t tri_map(input logic [CHAR_BITS-1:0] c);
		tri_map_t r;
		r.hit = 1'b1;
		case (c)
			8'h3D: r.ch = 8'h23; // = to #
			8'h27: r.ch = 8'h5E; // ' to ^
			8'h28: r.ch = 8'h5B; // ( to [
			8'h29: r.ch = 8'h5D; // ) to ]
			8'h21: r.ch = 8'h7C; // ! to |
			8'h3C: r.ch = 8'h7B; // < to {
			8'h3E: r.ch = 8'h7D; // > to }
			8'h2D: r.ch = 8'h7E; // - to ~
			default: begin
				r.hit = 1'b0;
				r.ch  = CH_NUL;
			end
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

@@ rtl/tlsf_front.sv @@
// front end: holds lookahead state and turns each input item into a work record
`default_nettype none

module tlsf_front (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         s_tvalid,
	output logic                              s_tready,
	input  wire logic [tlsf_pkg::CHAR_BITS-1:0] s_tdata,
	input  wire logic                         s_tlast,
	input  wire logic                         cfg_we,
	input  wire logic                         cfg_wdata,
	input  wire logic                         q_full,
	output logic                              push,
	output tlsf_pkg::tlsf_rec_t               rec
);

	logic       trig_en_q;
	logic [1:0] hq_q, hq_d;
	logic       hb_q, hb_d;
	logic       hcr_q, hcr_d;

	logic       accept;
	logic [tlsf_pkg::CHAR_BITS-1:0] c;
	tlsf_pkg::tri_map_t tm;
	logic       p_bsl, p_q;
	logic       use_plain;
	logic [1:0] n;

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;
	assign c        = s_tdata;
	assign tm       = tlsf_pkg::tri_map(c);

	// what an idle front would do with c
	assign p_bsl = (c == tlsf_pkg::CH_BSL);
	assign p_q   = (c == tlsf_pkg::CH_QMARK) && trig_en_q;

	always_comb begin
		rec       = '0;
		hq_d      = hq_q;
		hb_d      = hb_q;
		hcr_d     = hcr_q;
		use_plain = 1'b0;
		n         = 2'd0;
		if (s_tlast) begin
			hq_d  = 2'd0;
			hb_d  = 1'b0;
			hcr_d = 1'b0;
			rec.is_end = 1'b1;
			if (hb_q) begin
				rec.ch[0] = tlsf_pkg::CH_BSL;
				if (hcr_q) begin
					rec.ch[1] = tlsf_pkg::CH_CR;
					n = 2'd2;
				end else begin
					n = 2'd1;
				end
			end else if (hq_q[1]) begin
				rec.ch[0] = tlsf_pkg::CH_QMARK;
				rec.ch[1] = tlsf_pkg::CH_QMARK;
				n = 2'd2;
			end else if (hq_q[0]) begin
				rec.ch[0] = tlsf_pkg::CH_QMARK;
				n = 2'd1;
			end
			// end result sits in the slot after the flushed chars, char zero
			rec.cnt = n + 2'd1;
		end else begin
			if (hb_q) begin
				if (hcr_q) begin
					hb_d  = 1'b0;
					hcr_d = 1'b0;
					if (c == tlsf_pkg::CH_LF) begin
						rec.splice = 1'b1;
					end else begin
						rec.ch[0] = tlsf_pkg::CH_BSL;
						rec.ch[1] = tlsf_pkg::CH_CR;
						n = 2'd2;
						use_plain = 1'b1;
					end
				end else if (c == tlsf_pkg::CH_LF) begin
					hb_d = 1'b0;
					rec.splice = 1'b1;
				end else if (c == tlsf_pkg::CH_CR) begin
					hcr_d = 1'b1;
				end else begin
					hb_d = 1'b0;
					rec.ch[0] = tlsf_pkg::CH_BSL;
					n = 2'd1;
					use_plain = 1'b1;
				end
			end else if (hq_q[1]) begin
				hq_d = 2'd0;
				if (tm.hit) begin
					rec.ch[0] = tm.ch;
					n = 2'd1;
				end else if (c == tlsf_pkg::CH_SLASH) begin
					hb_d = 1'b1;
				end else if (p_q) begin
					// run of question marks: one leaves, the last two stay held
					rec.ch[0] = tlsf_pkg::CH_QMARK;
					n = 2'd1;
					hq_d = 2'd2;
				end else begin
					rec.ch[0] = tlsf_pkg::CH_QMARK;
					rec.ch[1] = tlsf_pkg::CH_QMARK;
					n = 2'd2;
					use_plain = 1'b1;
				end
			end else if (hq_q[0]) begin
				if (c == tlsf_pkg::CH_QMARK) begin
					hq_d = 2'd2;
				end else begin
					hq_d = 2'd0;
					rec.ch[0] = tlsf_pkg::CH_QMARK;
					n = 2'd1;
					use_plain = 1'b1;
				end
			end else begin
				use_plain = 1'b1;
			end
			rec.cnt = n;
			if (use_plain) begin
				if (p_bsl) begin
					hb_d = 1'b1;
				end else if (p_q) begin
					hq_d = 2'd1;
				end else begin
					rec.ch[n] = c;
					rec.cnt   = n + 2'd1;
				end
			end
		end
	end

	// items that only change the held state need no record
	assign push = accept && ((rec.cnt != 2'd0) || rec.splice);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trig_en_q <= 1'b1;
		end else if (cfg_we) begin
			trig_en_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hq_q  <= 2'd0;
			hb_q  <= 1'b0;
			hcr_q <= 1'b0;
		end else if (accept) begin
			hq_q  <= hq_d;
			hb_q  <= hb_d;
			hcr_q <= hcr_d;
		end
	end

endmodule

`default_nettype wire

@@ rtl/tlsf_queue.sv @@
// short record queue between front and back
`default_nettype none

module tlsf_queue (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire tlsf_pkg::tlsf_rec_t push_rec,
	input  wire logic                pop,
	output logic                     full,
	output logic                     not_empty,
	output tlsf_pkg::tlsf_rec_t      head
);

	tlsf_pkg::tlsf_rec_t entries_q [tlsf_pkg::Q_DEPTH];
	logic [tlsf_pkg::Q_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [tlsf_pkg::Q_AW:0]   count_q;
	logic                      do_pop;

	assign full      = (count_q == (tlsf_pkg::Q_AW+1)'(tlsf_pkg::Q_DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = entries_q[rd_ptr_q];
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/tlsf_back.sv @@
// back end: plays out queued records one result per cycle while the output is not stalled and keeps the line count
`default_nettype none

module tlsf_back (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            q_not_empty,
	input  wire tlsf_pkg::tlsf_rec_t             head,
	output logic                                 pop,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	output logic [tlsf_pkg::OUT_DATA_W-1:0]      m_tdata,
	output logic [1:0]                           m_tuser,
	output logic                                 m_tlast
);

	logic [tlsf_pkg::LINE_BITS-1:0] line_q, line_inc, line_out;
	logic [tlsf_pkg::CHAR_BITS-1:0] last_char_q, cur_ch;
	logic [1:0] idx_q;
	logic       out_valid_q;
	logic [tlsf_pkg::CHAR_BITS-1:0] out_char_q;
	logic [tlsf_pkg::LINE_BITS-1:0] out_line_q;
	logic       out_end_q, out_nfn_q, out_last_q;

	logic out_free, bare_splice, emit, last_slot, cur_end, cur_lf;

	assign out_free    = !out_valid_q || m_tready;
	assign bare_splice = q_not_empty && (head.cnt == 2'd0);
	assign emit        = q_not_empty && (head.cnt != 2'd0) && out_free;
	assign last_slot   = (idx_q == (head.cnt - 2'd1));
	assign cur_ch      = head.ch[idx_q];
	assign cur_end     = head.is_end && last_slot;
	assign cur_lf      = !cur_end && (cur_ch == tlsf_pkg::CH_LF);
	assign line_inc    = (line_q == tlsf_pkg::LINE_MAX) ? line_q : line_q + 1'b1;
	assign line_out    = cur_lf ? line_inc : line_q;
	assign pop         = bare_splice || (emit && last_slot);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q      <= tlsf_pkg::LINE_ONE;
			last_char_q <= tlsf_pkg::CH_NUL;
			idx_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (bare_splice) begin
				line_q <= line_inc;
			end else if (emit) begin
				idx_q <= last_slot ? 2'd0 : idx_q + 2'd1;
				if (cur_end) begin
					line_q <= tlsf_pkg::LINE_ONE;
				end else begin
					line_q      <= line_out;
					last_char_q <= cur_ch;
				end
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_char_q <= cur_end ? tlsf_pkg::CH_NUL : cur_ch;
			out_line_q <= line_out;
			out_end_q  <= cur_end;
			out_nfn_q  <= cur_end && (last_char_q != tlsf_pkg::CH_LF);
			out_last_q <= last_slot;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_line_q, out_char_q};
	assign m_tuser  = {out_nfn_q, out_end_q};
	assign m_tlast  = out_last_q;

endmodule

`default_nettype wire

@@ rtl/trigraph_line_splice_filter_unit.sv @@
// top level of the trigraph and line splice filter
`default_nettype none

// Takes one source byte per item (tlast marks the end of file) and gives
// translated characters with their line number. The front classifies each
// item in the cycle it is accepted, so input runs at one item per cycle as
// long as the four-record queue has room. The back plays out one result per
// cycle while m_tready allows, from a registered output stage; an item gives
// up to three results (a broken splice, an unmatched pair of question marks
// or an end-of-file flush), and a line splice is a record with no result.
// Items that only update the held lookahead push no record. Sustained rate
// is one item per cycle with m_tready high if items average at most one
// result (a splice as one). Trigraph translation is on after reset. The user
// sets it by cfg_we with cfg_wdata while the unit is idle; it is not enforced.
module trigraph_line_splice_filter_unit (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic                            cfg_wdata,   // trigraph_enable
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	input  wire logic [tlsf_pkg::CHAR_BITS-1:0]  s_tdata,     // in_byte
	input  wire logic                            s_tlast,     // end_of_input
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	output logic [tlsf_pkg::OUT_DATA_W-1:0]      m_tdata,     // out_char, line_count
	output logic [1:0]                           m_tuser,     // is_end, no_final_newline
	output logic                                 m_tlast      // last
);

	logic                q_full, q_not_empty, push, pop;
	tlsf_pkg::tlsf_rec_t push_rec, head;

	tlsf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.q_full    (q_full),
		.push      (push),
		.rec       (push_rec)
	);

	tlsf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_rec  (push_rec),
		.pop       (pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.head      (head)
	);

	tlsf_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.head        (head),
		.pop         (pop),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.m_tlast     (m_tlast)
	);

endmodule

`default_nettype wire

@@ rtl/tlsf_checker.sv @@
// port-level checks of the filter output, bound to the top level
`default_nettype none

`include "assert_macros.svh"

module tlsf_checker (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            m_tvalid,
	input wire logic                            m_tready,
	input wire logic [tlsf_pkg::OUT_DATA_W-1:0] m_tdata,
	input wire logic [1:0]                      m_tuser,
	input wire logic                            m_tlast
);

	`TLSF_ASSERT_NEXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid, "output item dropped while stalled")
	`TLSF_ASSERT_NEXT(a_hold_data, m_tvalid && !m_tready, $stable(m_tdata), "output item changed while stalled")
	`TLSF_ASSERT_NOW(a_end_last, m_tvalid && m_tuser[0], m_tlast && (m_tdata[7:0] == 8'h00), "end item not last or not zero")
	`TLSF_ASSERT_NOW(a_nfn_end, m_tvalid && m_tuser[1], m_tuser[0], "missing newline flag off end item")
	`TLSF_ASSERT_NOW(a_line_nz, m_tvalid, m_tdata[31:8] != 24'd0, "line count is zero")

endmodule

bind trigraph_line_splice_filter_unit tlsf_checker u_tlsf_checker (.*);

`default_nettype wire
